>>> sv/assert_macros.svh
// Assertion macros used by the top level of the container header parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clk edge outside reset.
`define VCHP_ASSERT_IMP(label, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clk edge outside reset.
`define VCHP_ASSERT_NXT(label, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error(msg);

`endif

>>> sv/vchp_pkg.sv
// Types, constants and helper functions of the container header parser.
`timescale 1ns / 1ps

package vchp_pkg;

  typedef logic [2:0] status_t;
  typedef logic [3:0] field_idx_t;

  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_SHORT     = 3'd1;
  localparam status_t ST_BAD_MAGIC = 3'd2;
  localparam status_t ST_BAD_VER   = 3'd3;
  localparam status_t ST_BAD_CODEC = 3'd4;
  localparam status_t ST_UNTERM    = 3'd5;
  localparam status_t ST_TRUNC     = 3'd6;

  localparam int HEADER_BYTES = 48;
  localparam int NUM_WORDS    = 11;
  localparam field_idx_t LAST_FIELD = 4'd11;
  localparam logic [5:0] LAST_HDR_POS = 6'd47;

  localparam logic [7:0] TAG_H = 8'h48;  // 'H'
  localparam logic [7:0] TAG_E = 8'h45;  // 'E'

  // One result event handed from the parser core to the result stage
  typedef struct packed {
    logic        valid;
    logic        ok;
    status_t     status;
    logic [31:0] offset;
  } vchp_event_t;

  // Where a header byte lands: word index and byte lane
  typedef struct packed {
    logic [3:0] idx;
    logic [1:0] lane;
  } vchp_slot_t;

  // Expected byte at the check positions 0..7: "MODS", "N3", codec 0x000a
  function automatic logic [7:0] hdr_expect(input logic [2:0] p);
    logic [7:0] e;
    case (p)
      3'd0:    e = 8'h4d;
      3'd1:    e = 8'h4f;
      3'd2:    e = 8'h44;
      3'd3:    e = 8'h53;
      3'd4:    e = 8'h4e;
      3'd5:    e = 8'h33;
      3'd6:    e = 8'h0a;
      default: e = 8'h00;
    endcase
    return e;
  endfunction

  // Error code that a mismatch at check position p reports
  function automatic status_t hdr_code(input logic [2:0] p);
    status_t c;
    case (p)
      3'd0, 3'd1, 3'd2, 3'd3: c = ST_BAD_MAGIC;
      3'd4, 3'd5:             c = ST_BAD_VER;
      default:                c = ST_BAD_CODEC;
    endcase
    return c;
  endfunction

  // Map a header byte position (8..47) to its word and lane
  function automatic vchp_slot_t hdr_slot(input logic [5:0] p);
    vchp_slot_t s;
    logic [5:0] d;
    d = '0;
    if (p < 6'h18) begin
      d      = p - 6'd8;
      s.idx  = {2'b00, d[3:2]};
      s.lane = p[1:0];
    end else if (p < 6'h1c) begin
      d      = p - 6'h18;
      s.idx  = 4'd4 + {3'b000, d[1]};
      s.lane = {1'b0, p[0]};
    end else begin
      d      = p - 6'h1c;
      s.idx  = 4'd6 + {1'b0, d[4:2]};
      s.lane = p[1:0];
    end
    return s;
  endfunction

endpackage

>>> sv/vchp_core.sv
// Parser core: byte position, header checks, header word capture, record walk.
`timescale 1ns / 1ps

module vchp_core #(
  parameter int POSITION_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic [7:0]           data_byte,
  input  logic                 final_byte,
  output logic                 finished,
  output vchp_pkg::vchp_event_t evt,
  output logic [31:0]          hdr_words [vchp_pkg::NUM_WORDS]
);
  import vchp_pkg::*;

  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  status_t                  pend_r, pend_nxt;
  logic [1:0]               phase_r, phase_nxt;
  logic                     tag_r, tag_nxt;
  logic [17:0]              pr_r, pr_nxt;
  logic                     fin_r, fin_nxt;
  logic [31:0]              hdr_r [NUM_WORDS];

  logic [5:0]  p;
  logic        in_hdr;
  logic        succ;
  logic        hdr_we;
  vchp_slot_t  slot;
  logic [17:0] pr_join;

  assign p      = pos_r[5:0];
  assign in_hdr = pos_r < POSITION_BITS'(HEADER_BYTES);
  assign slot   = hdr_slot(p);

  // Next state of the walk and the result event for the byte in hand
  always_comb begin
    pos_nxt   = pos_r;
    pend_nxt  = pend_r;
    phase_nxt = phase_r;
    tag_nxt   = tag_r;
    pr_nxt    = pr_r;
    fin_nxt   = fin_r;
    succ      = 1'b0;
    hdr_we    = 1'b0;
    pr_join   = pr_r | {2'b00, data_byte, 8'h00};
    evt       = '0;
    if (accept) begin
      if (fin_r) begin
        // drop bytes after a result until the buffer ends
        if (final_byte) begin
          pos_nxt   = '0;
          pend_nxt  = ST_OK;
          phase_nxt = '0;
          tag_nxt   = 1'b0;
          pr_nxt    = '0;
          fin_nxt   = 1'b0;
        end
      end else begin
        if (in_hdr) begin
          // check the fixed prefix, capture the header words
          if (p < 6'd8) begin
            if (data_byte != hdr_expect(p[2:0]) && pend_r == ST_OK) begin
              pend_nxt = hdr_code(p[2:0]);
            end
          end else begin
            hdr_we = 1'b1;
          end
          pos_nxt = pos_r + 1'b1;
          if (p == LAST_HDR_POS) begin
            if (pend_r != ST_OK) begin
              evt.valid  = 1'b1;
              evt.status = pend_r;
            end else if (final_byte) begin
              evt.valid  = 1'b1;
              evt.status = ST_UNTERM;
            end
          end else if (final_byte) begin
            evt.valid  = 1'b1;
            evt.status = ST_SHORT;
          end
        end else begin
          // walk the parameter records; position saturates
          if (!(&pos_r)) pos_nxt = pos_r + 1'b1;
          if (phase_r == 2'd0 && pr_r != '0) begin
            pr_nxt = pr_r - 1'b1;
            succ   = (pr_nxt == '0) && tag_r;
          end else begin
            case (phase_r)
              2'd0:    tag_nxt = (data_byte == TAG_H);
              2'd1:    tag_nxt = tag_r && (data_byte == TAG_E);
              2'd2:    pr_nxt  = {10'd0, data_byte};
              default: begin
                pr_nxt = {pr_join[15:0], 2'b00};
                succ   = (pr_nxt == '0) && tag_r;
              end
            endcase
            phase_nxt = phase_r + 2'd1;
          end
          if (succ) begin
            evt.valid  = 1'b1;
            evt.ok     = 1'b1;
            evt.status = ST_OK;
            evt.offset = 32'(pos_nxt);
          end else if (final_byte) begin
            evt.valid  = 1'b1;
            evt.status = (phase_nxt == 2'd0 && pr_nxt != '0) ? ST_TRUNC : ST_UNTERM;
          end
        end
        // a result either ends the buffer or parks the core until it ends
        if (evt.valid) begin
          if (final_byte) begin
            pos_nxt   = '0;
            pend_nxt  = ST_OK;
            phase_nxt = '0;
            tag_nxt   = 1'b0;
            pr_nxt    = '0;
            fin_nxt   = 1'b0;
          end else begin
            fin_nxt = 1'b1;
          end
        end
      end
    end
  end

  // Hold the walk state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      pend_r  <= ST_OK;
      phase_r <= '0;
      tag_r   <= 1'b0;
      pr_r    <= '0;
      fin_r   <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      pend_r  <= pend_nxt;
      phase_r <= phase_nxt;
      tag_r   <= tag_nxt;
      pr_r    <= pr_nxt;
      fin_r   <= fin_nxt;
    end
  end

  // Write one header byte into its word lane
  always_ff @(posedge clk) begin
    if (hdr_we) begin
      hdr_r[slot.idx][slot.lane*8 +: 8] <= data_byte;
    end
  end

  assign finished  = fin_r;
  assign hdr_words = hdr_r;

endmodule

>>> sv/vchp_emit.sv
// Result stage: holds one status result or steps through the twelve field results.
`timescale 1ns / 1ps

module vchp_emit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  vchp_pkg::vchp_event_t evt,
  input  logic [31:0]           hdr_words [vchp_pkg::NUM_WORDS],
  output logic                  out_valid,
  input  logic                  out_ready,
  output vchp_pkg::status_t     out_status,
  output vchp_pkg::field_idx_t  out_field_index,
  output logic [31:0]           out_field_value,
  output logic                  out_run_last
);
  import vchp_pkg::*;

  logic        valid_r, valid_nxt;
  logic        ok_r, ok_nxt;
  status_t     status_r, status_nxt;
  field_idx_t  idx_r, idx_nxt;
  logic [31:0] offset_r, offset_nxt;
  logic        pop;
  logic        last;
  logic [31:0] word;

  assign pop  = valid_r && out_ready;
  assign last = !ok_r || (idx_r == LAST_FIELD);

  // Load a new event, or advance through the run as items leave
  always_comb begin
    valid_nxt  = valid_r;
    ok_nxt     = ok_r;
    status_nxt = status_r;
    idx_nxt    = idx_r;
    offset_nxt = offset_r;
    if (evt.valid) begin
      valid_nxt  = 1'b1;
      ok_nxt     = evt.ok;
      status_nxt = evt.status;
      idx_nxt    = '0;
      offset_nxt = evt.offset;
    end else if (pop) begin
      if (last) valid_nxt = 1'b0;
      else      idx_nxt   = idx_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      ok_r    <= 1'b0;
      idx_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      ok_r    <= ok_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    offset_r <= offset_nxt;
  end

  // Select the field value; the two 16-bit words are zero-extended
  always_comb begin
    word = '0;
    if (!ok_r) begin
      word = '0;
    end else if (idx_r == LAST_FIELD) begin
      word = offset_r;
    end else if (idx_r == 4'd4 || idx_r == 4'd5) begin
      word = {16'h0000, hdr_words[idx_r][15:0]};
    end else if (idx_r < LAST_FIELD) begin
      word = hdr_words[idx_r];
    end
  end

  assign out_valid       = valid_r;
  assign out_status      = status_r;
  assign out_field_index = ok_r ? idx_r : '0;
  assign out_field_value = word;
  assign out_run_last    = last;

endmodule

>>> sv/video_container_header_parser.sv
// Top level of the video container header parser.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Takes one container byte per cycle while in_ready is high (in_final_byte
// marks the buffer's last byte) and answers with one status result on a
// failed header or record list, or a run of twelve results on success: header
// words 0..10, then the packet data offset, one result per cycle as out_ready
// allows. A result is captured in the result register at the edge that
// accepts the byte raising it and is offered from the next cycle. While a
// result waits there, input stalls unless the parser is parked after that
// result (bytes up to the final byte are then taken every cycle and dropped)
// or the last item of the waiting run leaves in the same cycle; the header
// bytes of a new buffer would otherwise overwrite header words still being
// read out. A success run that ends a buffer thus holds off the next buffer.
// The byte counter is POSITION_BITS wide and saturates.
module video_container_header_parser #(
  parameter int POSITION_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_final_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output vchp_pkg::status_t    out_status,
  output vchp_pkg::field_idx_t out_field_index,
  output logic [31:0]          out_field_value,
  output logic                 out_run_last
);
  import vchp_pkg::*;

  logic         accept;
  logic         finished;
  vchp_event_t  evt;
  logic [31:0]  hdr_words [NUM_WORDS];

  // Take bytes while the result register is free or being emptied, or the parser is parked
  assign in_ready = finished || !out_valid || (out_ready && out_run_last);
  assign accept   = in_valid && in_ready;

  vchp_core #(
    .POSITION_BITS(POSITION_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .data_byte  (in_data_byte),
    .final_byte (in_final_byte),
    .finished   (finished),
    .evt        (evt),
    .hdr_words  (hdr_words)
  );

  vchp_emit u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .evt             (evt),
    .hdr_words       (hdr_words),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_field_index (out_field_index),
    .out_field_value (out_field_value),
    .out_run_last    (out_run_last)
  );

  `VCHP_ASSERT_IMP(a_err_single, out_valid && out_status != ST_OK, out_run_last && out_field_index == 4'd0, "status result must be a single item at index zero")
  `VCHP_ASSERT_IMP(a_run_end, out_valid && out_status == ST_OK && out_run_last, out_field_index == LAST_FIELD, "run must end on the offset field")
  `VCHP_ASSERT_NXT(a_run_step, out_valid && out_ready && !out_run_last, out_valid && out_field_index == $past(out_field_index) + 4'd1, "run index must advance by one")
  `VCHP_ASSERT_IMP(a_no_clobber, evt.valid && out_valid, out_ready && out_run_last, "new result would overwrite a pending item")

endmodule
